// File: rtl/bsc_pkg.sv
// Shared types and constants for the breakpoint session controller.
// No dependencies; used by breakpoint_session_controller_core.
package bsc_pkg;

   // Breakpoint slot storage
   localparam int MAX_BREAKPOINTS = 16;
   localparam int SLOT_IDX_W      = $clog2(MAX_BREAKPOINTS);
   localparam int BP_COUNT_W      = $clog2(MAX_BREAKPOINTS + 1);

   // Fixed field widths
   localparam int MODE_W     = 3;
   localparam int PROBE_W    = 64;
   localparam int SLOT_FLD_W = 4;
   localparam int COUNT_W    = 32;
   localparam int STATE_W    = 2;

   // Command codes carried in the mode field
   typedef enum logic [MODE_W-1:0] {
      CMD_PROBE      = 3'd0,
      CMD_ATTACH     = 3'd1,
      CMD_DETACH     = 3'd2,
      CMD_REQ_PAUSE  = 3'd3,
      CMD_CONTINUE   = 3'd4,
      CMD_STEP_INTO  = 3'd5,
      CMD_GEN_CHANGE = 3'd6,
      CMD_SLOT_WRITE = 3'd7
   } cmd_type;

   // Session state machine, one-hot
   typedef enum logic [2:0] {
      SES_DETACHED = 3'b001,
      SES_RUNNING  = 3'b010,
      SES_PAUSED   = 3'b100
   } session_type;

   // Encoded session state as reported on the result word
   localparam logic [STATE_W-1:0] SES_CODE_DETACHED = 2'd0;
   localparam logic [STATE_W-1:0] SES_CODE_RUNNING  = 2'd1;
   localparam logic [STATE_W-1:0] SES_CODE_PAUSED   = 2'd2;

   // Run mode, reported as is
   typedef enum logic [STATE_W-1:0] {
      RM_CONTINUE   = 2'd0,
      RM_PAUSE_NEXT = 2'd1,
      RM_STEP_INTO  = 2'd2
   } run_mode_type;

endpackage

// File: rtl/breakpoint_session_controller_core.sv
// Breakpoint session controller: command decode, session state and breakpoint slots.
// Depends on bsc_pkg for command, state and run mode types and slot constants.
//
//   channel | direction | ports                                          | handshake
//   req     | in        | mode, probe_id, slot_index, slot_enable        | valid/ready
//   rsp     | out       | accepted, pause_action, session_state, ...     | valid/ready
//
// One command word per cycle unless the result side stalls; an accepted word goes
// through the input register, then decode/update into the result register.
// Every probe is compared against all breakpoint slots in parallel.
// Reset is synchronous: detached, continue mode, counters zero, all slots invalid.
// A stalled result holds in its register; req_ready drops only when both the
// input and result registers are full and rsp_ready is low.
module breakpoint_session_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bsc_pkg::MODE_W-1:0]        req_mode,
   input  logic [bsc_pkg::PROBE_W-1:0]       req_probe_id,
   input  logic [bsc_pkg::SLOT_FLD_W-1:0]    req_slot_index,
   input  logic                              req_slot_enable,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_pause_action,
   output logic [bsc_pkg::STATE_W-1:0]       rsp_session_state,
   output logic [bsc_pkg::STATE_W-1:0]       rsp_run_mode_now,
   output logic [bsc_pkg::COUNT_W-1:0]       rsp_epoch_count,
   output logic [bsc_pkg::COUNT_W-1:0]       rsp_pause_count,
   output logic [bsc_pkg::PROBE_W-1:0]       rsp_active_probe,
   output logic [bsc_pkg::BP_COUNT_W-1:0]    rsp_breakpoint_count
);

   // Input register
   logic                              in_valid_ff;
   bsc_pkg::cmd_type                  in_mode_ff;
   logic [bsc_pkg::PROBE_W-1:0]       in_probe_ff;
   logic [bsc_pkg::SLOT_FLD_W-1:0]    in_slot_idx_ff;
   logic                              in_slot_en_ff;

   // Session state
   bsc_pkg::session_type              ses_ff, ses_in;
   bsc_pkg::run_mode_type             rmode_ff, rmode_in;
   logic [bsc_pkg::COUNT_W-1:0]       epoch_ff, epoch_in;
   logic [bsc_pkg::COUNT_W-1:0]       pcount_ff, pcount_in;
   logic [bsc_pkg::PROBE_W-1:0]       active_ff, active_in;
   logic                              supp_valid_ff, supp_valid_in;
   logic [bsc_pkg::PROBE_W-1:0]       supp_probe_ff, supp_probe_in;
   logic [bsc_pkg::BP_COUNT_W-1:0]    bp_count_ff, bp_count_in;

   // Breakpoint slots
   logic                              slot_valid_ff [bsc_pkg::MAX_BREAKPOINTS];
   logic [bsc_pkg::PROBE_W-1:0]       slot_id_ff    [bsc_pkg::MAX_BREAKPOINTS];

   // Result register
   logic                              rsp_valid_ff;
   logic                              rsp_acc_ff, rsp_acc_in;
   logic                              rsp_pause_ff, rsp_pause_in;
   logic [bsc_pkg::STATE_W-1:0]       rsp_state_ff, rsp_state_in;

   logic                              fire;
   logic                              slot_hit;
   logic                              slot_wr;
   logic [bsc_pkg::SLOT_IDX_W-1:0]    slot_sel;
   logic                              slot_old;

   // Advance the decode stage when the result register is free or being drained
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff     <= bsc_pkg::cmd_type'(req_mode);
         in_probe_ff    <= req_probe_id;
         in_slot_idx_ff <= req_slot_index;
         in_slot_en_ff  <= req_slot_enable;
      end
   end

   // Compare the probe against every valid slot
   always_comb begin
      slot_hit = 1'b0;
      for (int i = 0; i < bsc_pkg::MAX_BREAKPOINTS; i++) begin
         if (slot_valid_ff[i] && (slot_id_ff[i] == in_probe_ff)) begin
            slot_hit = 1'b1;
         end
      end
   end

   assign slot_sel = in_slot_idx_ff[bsc_pkg::SLOT_IDX_W-1:0];
   assign slot_old = slot_valid_ff[slot_sel];
   assign slot_wr  = fire && (in_mode_ff == bsc_pkg::CMD_SLOT_WRITE)
                     && (32'(in_slot_idx_ff) < bsc_pkg::MAX_BREAKPOINTS);

   // Decode the command and compute the next session state
   always_comb begin
      ses_in        = ses_ff;
      rmode_in      = rmode_ff;
      epoch_in      = epoch_ff;
      pcount_in     = pcount_ff;
      active_in     = active_ff;
      supp_valid_in = supp_valid_ff;
      supp_probe_in = supp_probe_ff;
      bp_count_in   = bp_count_ff;
      rsp_acc_in    = 1'b1;
      rsp_pause_in  = 1'b0;

      case (in_mode_ff)
         bsc_pkg::CMD_PROBE: begin
            case (ses_ff)
               bsc_pkg::SES_DETACHED: begin
                  rsp_pause_in = 1'b0;
               end
               bsc_pkg::SES_PAUSED: begin
                  rsp_pause_in = 1'b1;
               end
               bsc_pkg::SES_RUNNING: begin
                  // First probe after a resume passes once if it is the paused id
                  supp_valid_in = 1'b0;
                  if (supp_valid_ff && (supp_probe_ff == in_probe_ff)) begin
                     rsp_pause_in = 1'b0;
                  end else if ((rmode_ff != bsc_pkg::RM_CONTINUE) || slot_hit) begin
                     rsp_pause_in = 1'b1;
                     ses_in       = bsc_pkg::SES_PAUSED;
                     rmode_in     = bsc_pkg::RM_CONTINUE;
                     active_in    = in_probe_ff;
                     pcount_in    = pcount_ff + bsc_pkg::COUNT_W'(1);
                  end
               end
               default: begin
                  rsp_pause_in = 1'b0;
               end
            endcase
         end
         bsc_pkg::CMD_ATTACH: begin
            epoch_in      = epoch_ff + bsc_pkg::COUNT_W'(1);
            ses_in        = bsc_pkg::SES_RUNNING;
            rmode_in      = bsc_pkg::RM_CONTINUE;
            supp_valid_in = 1'b0;
            active_in     = '0;
         end
         bsc_pkg::CMD_DETACH: begin
            epoch_in      = epoch_ff + bsc_pkg::COUNT_W'(1);
            ses_in        = bsc_pkg::SES_DETACHED;
            rmode_in      = bsc_pkg::RM_CONTINUE;
            supp_valid_in = 1'b0;
            active_in     = '0;
            bp_count_in   = '0;
         end
         bsc_pkg::CMD_REQ_PAUSE: begin
            if (ses_ff == bsc_pkg::SES_RUNNING) begin
               rmode_in = bsc_pkg::RM_PAUSE_NEXT;
            end else begin
               rsp_acc_in = 1'b0;
            end
         end
         bsc_pkg::CMD_CONTINUE, bsc_pkg::CMD_STEP_INTO: begin
            if (ses_ff == bsc_pkg::SES_PAUSED) begin
               supp_valid_in = 1'b1;
               supp_probe_in = active_ff;
               active_in     = '0;
               ses_in        = bsc_pkg::SES_RUNNING;
               rmode_in      = (in_mode_ff == bsc_pkg::CMD_CONTINUE) ?
                               bsc_pkg::RM_CONTINUE : bsc_pkg::RM_STEP_INTO;
            end else begin
               rsp_acc_in = 1'b0;
            end
         end
         bsc_pkg::CMD_GEN_CHANGE: begin
            epoch_in      = epoch_ff + bsc_pkg::COUNT_W'(1);
            rmode_in      = bsc_pkg::RM_CONTINUE;
            supp_valid_in = 1'b0;
            active_in     = '0;
            if (ses_ff != bsc_pkg::SES_DETACHED) begin
               ses_in = bsc_pkg::SES_RUNNING;
            end
         end
         bsc_pkg::CMD_SLOT_WRITE: begin
            // Track the valid slot total incrementally
            if (32'(in_slot_idx_ff) < bsc_pkg::MAX_BREAKPOINTS) begin
               bp_count_in = bp_count_ff - bsc_pkg::BP_COUNT_W'(slot_old)
                             + bsc_pkg::BP_COUNT_W'(in_slot_en_ff);
            end
         end
         default: begin
            rsp_acc_in = 1'b1;
         end
      endcase
   end

   // Encode the session state for the result word
   always_comb begin
      case (ses_in)
         bsc_pkg::SES_DETACHED: rsp_state_in = bsc_pkg::SES_CODE_DETACHED;
         bsc_pkg::SES_RUNNING:  rsp_state_in = bsc_pkg::SES_CODE_RUNNING;
         bsc_pkg::SES_PAUSED:   rsp_state_in = bsc_pkg::SES_CODE_PAUSED;
         default:               rsp_state_in = bsc_pkg::SES_CODE_DETACHED;
      endcase
   end

   // Update session state on each decoded word
   always_ff @(posedge clock) begin
      if (reset) begin
         ses_ff        <= bsc_pkg::SES_DETACHED;
         rmode_ff      <= bsc_pkg::RM_CONTINUE;
         epoch_ff      <= '0;
         pcount_ff     <= '0;
         active_ff     <= '0;
         supp_valid_ff <= 1'b0;
         supp_probe_ff <= '0;
         bp_count_ff   <= '0;
      end else if (fire) begin
         ses_ff        <= ses_in;
         rmode_ff      <= rmode_in;
         epoch_ff      <= epoch_in;
         pcount_ff     <= pcount_in;
         active_ff     <= active_in;
         supp_valid_ff <= supp_valid_in;
         supp_probe_ff <= supp_probe_in;
         bp_count_ff   <= bp_count_in;
      end
   end

   // Slot valid bits: detach drops them all, a slot write sets or clears one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsc_pkg::MAX_BREAKPOINTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else if (fire && (in_mode_ff == bsc_pkg::CMD_DETACH)) begin
         for (int i = 0; i < bsc_pkg::MAX_BREAKPOINTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else if (slot_wr) begin
         slot_valid_ff[slot_sel] <= in_slot_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_wr) begin
         slot_id_ff[slot_sel] <= in_probe_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_acc_ff   <= rsp_acc_in;
         rsp_pause_ff <= rsp_pause_in;
         rsp_state_ff <= rsp_state_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_acc_ff;
   assign rsp_pause_action     = rsp_pause_ff;
   assign rsp_session_state    = rsp_state_ff;
   assign rsp_run_mode_now     = rmode_ff;
   assign rsp_epoch_count      = epoch_ff;
   assign rsp_pause_count      = pcount_ff;
   assign rsp_active_probe     = active_ff;
   assign rsp_breakpoint_count = bp_count_ff;

   // The snapshot fields above come straight from state, which only moves on
   // fire, i.e. together with a fresh result word, so they hold while stalled.

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bp_count_ff) <= bsc_pkg::MAX_BREAKPOINTS)
      else $error("breakpoint count above slot total");

   a_detach_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_mode_ff == bsc_pkg::CMD_DETACH)) |=> (bp_count_ff == '0))
      else $error("detach left breakpoints counted");

   a_active_paused: assert property (@(posedge clock) disable iff (reset)
      (ses_ff != bsc_pkg::SES_PAUSED) |-> (active_ff == '0))
      else $error("active probe set while not paused");

   a_pause_only_probe: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_mode_ff != bsc_pkg::CMD_PROBE)) |=> $stable(pcount_ff))
      else $error("pause count moved on a non-probe command");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule
